[rtl/tkgc_pkg.sv]
// ----------------------------------------------------------------------------
// tkgc_pkg
// shared types, register codes and the speed clamp for the gesture controller
// ----------------------------------------------------------------------------
package tkgc_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_DEBOUNCE   = 3'd0;
  localparam logic [2:0] REG_LONG_TICKS = 3'd1;
  localparam logic [2:0] REG_SPD_FLOOR  = 3'd2;
  localparam logic [2:0] REG_SPD_CEIL   = 3'd3;
  localparam logic [2:0] REG_SPD_INC    = 3'd4;

  // reset values
  localparam logic [3:0] DEBOUNCE_RST   = 4'd3;
  localparam logic [9:0] LONG_TICKS_RST = 10'd40;
  localparam logic [6:0] SPD_FLOOR_RST  = 7'd5;
  localparam logic [6:0] SPD_CEIL_RST   = 7'd15;
  localparam logic [3:0] SPD_INC_RST    = 4'd1;
  localparam logic [6:0] SPEED_RST      = 7'd5;

  typedef struct packed {
    logic [3:0] debounce_samples;
    logic [9:0] long_press_ticks;
    logic [6:0] spd_floor;
    logic [6:0] spd_ceil;
    logic [3:0] spd_inc;
  } cfg_t;

  // merge stage to lane control
  typedef struct packed {
    logic gesture_en;   // single-key gestures active this tick
    logic chord_start;  // chord fires this tick, cancel gestures
  } lane_ctrl_t;

  // lane to merge stage results
  typedef struct packed {
    logic fire;  // short press released this tick
    logic turn;  // long flag after this tick
  } lane_res_t;

  typedef struct packed {
    logic       motor_toggled;
    logic       speed_changed;
    logic [6:0] speed;
    logic       motor_on;
    logic       right_turn;
    logic       left_turn;
  } result_t;

  // min clamp first, then max clamp
  function automatic logic [6:0] clamp_speed(input logic signed [8:0] v,
                                             input logic [6:0] lo,
                                             input logic [6:0] hi);
    logic signed [8:0] t;
    t = v;
    if (t < $signed({2'b00, lo})) t = $signed({2'b00, lo});
    if (t > $signed({2'b00, hi})) t = $signed({2'b00, hi});
    return t[6:0];
  endfunction

endpackage

[rtl/tkgc_key_lane.sv]
// ----------------------------------------------------------------------------
// tkgc_key_lane
// one key: debounce, hold counter, long flag and short press detection
// ----------------------------------------------------------------------------
module tkgc_key_lane #(
  parameter int HOLD_BITS = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                raw,
  input  tkgc_pkg::cfg_t      cfg,
  input  tkgc_pkg::lane_ctrl_t ctrl,
  output logic                pressed,
  output tkgc_pkg::lane_res_t res
);
  import tkgc_pkg::*;

  localparam int CW = (HOLD_BITS > 10) ? HOLD_BITS : 10;
  localparam logic [HOLD_BITS-1:0] HOLD_MAX = {HOLD_BITS{1'b1}};

  logic                 smp_prev, smp_prev_next;
  logic                 stable, stable_next;
  logic [3:0]           eq_run, eq_run_next;
  logic                 prev_pressed;
  logic                 press_valid, press_valid_next;
  logic [HOLD_BITS-1:0] hold_count, hold_count_next;
  logic                 is_long, is_long_next;
  logic                 fire;

  // debounce
  always_comb begin
    smp_prev_next = smp_prev;
    eq_run_next   = eq_run;
    stable_next   = stable;
    if (raw == smp_prev) begin
      if (eq_run < cfg.debounce_samples) eq_run_next = eq_run + 4'd1;
    end else begin
      eq_run_next   = 4'd1;
      smp_prev_next = raw;
    end
    if (eq_run_next >= cfg.debounce_samples) stable_next = raw;
  end

  assign pressed = ~stable_next;

  // gesture
  always_comb begin
    press_valid_next = press_valid;
    hold_count_next  = hold_count;
    is_long_next     = is_long;
    fire             = 1'b0;
    if (ctrl.chord_start) begin
      press_valid_next = 1'b0;
      is_long_next     = 1'b0;
    end else if (ctrl.gesture_en) begin
      if (pressed && !prev_pressed) begin
        press_valid_next = 1'b1;
        hold_count_next  = '0;
        is_long_next     = 1'b0;
      end else if (pressed && press_valid) begin
        if (hold_count != HOLD_MAX) hold_count_next = hold_count + 1'b1;
      end
      if (pressed && !is_long_next && press_valid_next &&
          (CW'(hold_count_next) >= CW'(cfg.long_press_ticks)))
        is_long_next = 1'b1;
      if (!pressed && prev_pressed) begin
        if (is_long_next) is_long_next = 1'b0;
        else if (press_valid_next) fire = 1'b1;
        press_valid_next = 1'b0;
      end
    end
  end

  assign res.fire = fire;
  assign res.turn = is_long_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      smp_prev     <= 1'b1;
      stable       <= 1'b1;
      eq_run       <= DEBOUNCE_RST;
      prev_pressed <= 1'b0;
      press_valid  <= 1'b0;
      hold_count   <= '0;
      is_long      <= 1'b0;
    end else if (step) begin
      smp_prev     <= smp_prev_next;
      stable       <= stable_next;
      eq_run       <= eq_run_next;
      prev_pressed <= pressed;
      press_valid  <= press_valid_next;
      hold_count   <= hold_count_next;
      is_long      <= is_long_next;
    end
  end

endmodule

[rtl/tkgc_merge.sv]
// ----------------------------------------------------------------------------
// tkgc_merge
// combines both lanes: chord detection, motor toggle and speed stepping
// ----------------------------------------------------------------------------
module tkgc_merge (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  tkgc_pkg::cfg_t       cfg,
  input  logic                 left_pressed,
  input  logic                 right_pressed,
  input  tkgc_pkg::lane_res_t  left_res,
  input  tkgc_pkg::lane_res_t  right_res,
  output tkgc_pkg::lane_ctrl_t ctrl,
  output tkgc_pkg::result_t    res
);
  import tkgc_pkg::*;

  logic       chord_lock, chord_lock_next;
  logic       motor_enable, motor_enable_next;
  logic [6:0] speed_value, speed_value_next;
  logic [6:0] speed_left;
  logic       both;

  assign both             = left_pressed & right_pressed;
  assign ctrl.chord_start = both & ~chord_lock;
  assign ctrl.gesture_en  = ~both & ~chord_lock;

  always_comb begin
    chord_lock_next   = chord_lock;
    motor_enable_next = motor_enable;
    if (ctrl.chord_start) begin
      chord_lock_next   = 1'b1;
      motor_enable_next = ~motor_enable;
    end else if (chord_lock && !left_pressed && !right_pressed) begin
      chord_lock_next = 1'b0;
    end
  end

  // left steps up first, right steps down from that result
  always_comb begin
    speed_left = speed_value;
    if (left_res.fire)
      speed_left = clamp_speed($signed({2'b00, speed_value}) +
                               $signed({5'b00000, cfg.spd_inc}),
                               cfg.spd_floor, cfg.spd_ceil);
    speed_value_next = speed_left;
    if (right_res.fire)
      speed_value_next = clamp_speed($signed({2'b00, speed_left}) -
                                     $signed({5'b00000, cfg.spd_inc}),
                                     cfg.spd_floor, cfg.spd_ceil);
  end

  assign res.left_turn     = left_res.turn;
  assign res.right_turn    = right_res.turn;
  assign res.motor_on      = motor_enable_next;
  assign res.speed         = speed_value_next;
  assign res.speed_changed = left_res.fire | right_res.fire;
  assign res.motor_toggled = ctrl.chord_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      chord_lock   <= 1'b0;
      motor_enable <= 1'b0;
      speed_value  <= SPEED_RST;
    end else if (step) begin
      chord_lock   <= chord_lock_next;
      motor_enable <= motor_enable_next;
      speed_value  <= speed_value_next;
    end
  end

endmodule

[rtl/two_key_gesture_controller_core.sv]
// ----------------------------------------------------------------------------
// two_key_gesture_controller_core
// two-key debounce, short/long press and chord controller, one tick per item
// ----------------------------------------------------------------------------
// a result appears on m_tvalid in the cycle after its item is accepted
// throughput: one item per cycle while s_tready is high, set by the lane and merge update
// the output register frees whenever its result is taken, so s_tready only
// drops while a result waits with m_tready low
// reset: synchronous, clears config to defaults, key, chord, motor and speed state, output valid
module two_key_gesture_controller_core #(
  parameter int HOLD_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] left_raw, [1] right_raw
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [0] left_turn, [1] right_turn, [2] motor_on,
                                 // [9:3] speed, [10] speed_changed,
                                 // [11] motor_toggled
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data
);
  import tkgc_pkg::*;

  cfg_t       cfg;
  lane_ctrl_t ctrl;
  lane_res_t  left_res, right_res;
  result_t    res, out_res;
  logic       left_pressed, right_pressed;
  logic       accept;

  // output register parts the two sides; a taken result frees it at once
  assign s_tready  = ~m_tvalid | m_tready;
  assign accept    = s_tvalid & s_tready;
  assign cfg_ready = 1'b1;

  // configuration registers, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_samples <= DEBOUNCE_RST;
      cfg.long_press_ticks <= LONG_TICKS_RST;
      cfg.spd_floor        <= SPD_FLOOR_RST;
      cfg.spd_ceil         <= SPD_CEIL_RST;
      cfg.spd_inc          <= SPD_INC_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DEBOUNCE:   cfg.debounce_samples <= cfg_data[3:0];
        REG_LONG_TICKS: cfg.long_press_ticks <= cfg_data;
        REG_SPD_FLOOR:  cfg.spd_floor        <= cfg_data[6:0];
        REG_SPD_CEIL:   cfg.spd_ceil         <= cfg_data[6:0];
        REG_SPD_INC:    cfg.spd_inc          <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // one lane per key
  tkgc_key_lane #(.HOLD_BITS(HOLD_BITS)) u_left (
    .clk     (clk),
    .rst     (rst),
    .step    (accept),
    .raw     (s_tdata[0]),
    .cfg     (cfg),
    .ctrl    (ctrl),
    .pressed (left_pressed),
    .res     (left_res)
  );

  tkgc_key_lane #(.HOLD_BITS(HOLD_BITS)) u_right (
    .clk     (clk),
    .rst     (rst),
    .step    (accept),
    .raw     (s_tdata[1]),
    .cfg     (cfg),
    .ctrl    (ctrl),
    .pressed (right_pressed),
    .res     (right_res)
  );

  // chord, motor and speed from both lanes
  tkgc_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .step          (accept),
    .cfg           (cfg),
    .left_pressed  (left_pressed),
    .right_pressed (right_pressed),
    .left_res      (left_res),
    .right_res     (right_res),
    .ctrl          (ctrl),
    .res           (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) out_res <= res;
  end

  assign m_tdata = {4'b0000, out_res};

`ifndef SYNTH
  // an accepted item always leaves a result waiting
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted item produced no result");

  // the motor bit flips against its stored state exactly on a chord toggle
  a_toggle_flips: assert property (@(posedge clk) disable iff (rst)
    accept |-> ((res.motor_on != u_merge.motor_enable) == ctrl.chord_start))
    else $error("motor bit does not follow the chord toggle");

  // a chord cancels both long flags
  a_chord_cancels: assert property (@(posedge clk) disable iff (rst)
    accept && ctrl.chord_start |=> !out_res.left_turn && !out_res.right_turn)
    else $error("chord left a turn flag set");

  // no short press is taken while a chord is underway
  a_no_fire_in_chord: assert property (@(posedge clk) disable iff (rst)
    !ctrl.gesture_en |-> !left_res.fire && !right_res.fire)
    else $error("short press during chord");
`endif

endmodule
